// ===== rtl/swmf_pkg.sv =====
// Package: shared types, constants and codes for the sliding window median filter.
`timescale 1ns / 1ps
`default_nettype none
package swmf_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_WINDOW_DEF  = 31;
  localparam int CNT_W           = 16;
  localparam int CELL_W          = 3 * SAMPLE_BITS;
  localparam int CFG_AW          = 1;
  localparam int CFG_DW          = 5;
  localparam int WIN_CFG_W       = 5;
  localparam int QTY_W           = 2;
  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 5'd3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_WIN_LEN  = 1'b0,
    CFG_QUANTITY = 1'b1
  } swmf_cfg_t;

  typedef enum logic [QTY_W-1:0] {
    QTY_VELOCITY = 2'd0,
    QTY_POWER    = 2'd1,
    QTY_WIDTH    = 2'd2,
    QTY_NONE     = 2'd3
  } swmf_qty_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_RAW,
    S_SORT,
    S_FIN,
    S_EMIT
  } swmf_state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] velocity;
    logic signed [SAMPLE_BITS-1:0] power;
    logic signed [SAMPLE_BITS-1:0] spectral_width;
    logic                          last;
  } swmf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_velocity;
    logic signed [SAMPLE_BITS-1:0] out_power;
    logic signed [SAMPLE_BITS-1:0] out_width;
    logic                          out_last;
  } swmf_out_t;

  typedef struct packed {
    logic accept;
    logic rd_raw;
    logic rd_sort;
    logic emit;
  } swmf_cmd_t;

  typedef struct packed {
    logic pending;
    logic filt;
    logic sort_done;
    logic out_free;
  } swmf_sts_t;

endpackage
`default_nettype wire

// ===== rtl/swmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module swmf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/swmf_sort.sv =====
// Insertion sorter: one sample per cycle while insert is high into a sorted register row, median tap.
`timescale 1ns / 1ps
`default_nettype none
module swmf_sort
  import swmf_pkg::*;
#(
  parameter int LANES = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            clear,
  input  wire logic                            insert,
  input  wire logic signed [SAMPLE_BITS-1:0]   value,
  input  wire logic [$clog2(LANES)-1:0]        sel,
  output logic signed      [SAMPLE_BITS-1:0]   median
);

  localparam int AW = $clog2(LANES);

  logic signed [SAMPLE_BITS-1:0] sorted      [LANES];
  logic signed [SAMPLE_BITS-1:0] sorted_next [LANES];
  logic [AW-1:0]                 cnt;
  logic [LANES-1:0]              le;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      le[i] = (AW'(i) < cnt) && (sorted[i] <= value);
    end
    for (int i = 0; i < LANES; i++) begin
      if (le[i]) begin
        sorted_next[i] = sorted[i];
      end else if (i == 0) begin
        sorted_next[i] = value;
      end else if (le[i-1]) begin
        sorted_next[i] = value;
      end else begin
        sorted_next[i] = sorted[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      sorted <= sorted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= '0;
    end else if (insert) begin
      cnt <= cnt + AW'(1);
    end
  end

  assign median = sorted[sel];

endmodule
`default_nettype wire

// ===== rtl/swmf_ctrl.sv =====
// Controller state machine: sequences accept, buffer reads, sorting and emission.
`timescale 1ns / 1ps
`default_nettype none
module swmf_ctrl
  import swmf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire swmf_sts_t sts,
  output swmf_cmd_t      cmd
);

  swmf_state_t state;
  swmf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PLAN;
      end
      S_PLAN: begin
        state_next = sts.pending ? S_RAW : S_IDLE;
      end
      S_RAW: begin
        state_next = sts.filt ? S_SORT : S_FIN;
      end
      S_SORT: begin
        if (sts.sort_done) state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_next = S_PLAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_RAW:  cmd.rd_raw  = 1'b1;
      S_SORT: cmd.rd_sort = 1'b1;
      S_EMIT: cmd.emit    = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/swmf_dp.sv =====
// Datapath: cell ring, record bookkeeping, sorter feed and output register.
`timescale 1ns / 1ps
`default_nettype none
module swmf_dp
  import swmf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire swmf_cmd_t         cmd,
  output swmf_sts_t              sts,
  input  wire swmf_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swmf_out_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH = 1 << AW;

  logic [WIN_CFG_W-1:0] win_len;
  logic [QTY_W-1:0]     quantity;
  logic [AW-1:0]        act_window;
  logic [QTY_W-1:0]     act_quantity;
  logic [CNT_W-1:0]     cells_seen;
  logic [AW-1:0]        wr_pos;
  logic                 main_pend;
  logic                 main_filt;
  logic                 main_last;
  logic [AW-1:0]        fl_cnt;
  logic [AW-1:0]        k;
  logic                 raw_vld;
  logic                 sort_vld;
  logic [CELL_W-1:0]    held_cell;

  logic [AW-1:0]        clamp_w;
  logic [AW-1:0]        eff_w;
  logic [QTY_W-1:0]     eff_q;
  logic [AW-1:0]        eff_h;
  logic [AW-1:0]        eff_2h;
  logic                 first;
  logic                 c_ge_h;
  logic                 c_ge_2h;
  logic [AW-1:0]        h_cur;
  logic [AW-1:0]        two_h;
  logic [AW-1:0]        raw_back;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [CELL_W-1:0]    rd_data;
  logic [CELL_W-1:0]    wr_data;
  logic signed [SAMPLE_BITS-1:0] sort_val;
  logic signed [SAMPLE_BITS-1:0] median;
  logic signed [SAMPLE_BITS-1:0] vel;
  logic signed [SAMPLE_BITS-1:0] pwr;
  logic signed [SAMPLE_BITS-1:0] wid;
  logic                 cur_filt;
  logic                 cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len  <= WINDOW_RESET;
      quantity <= QTY_VELOCITY;
    end else if (cfg_we) begin
      case (swmf_cfg_t'(cfg_addr))
        CFG_WIN_LEN:  win_len  <= cfg_wdata[WIN_CFG_W-1:0];
        CFG_QUANTITY: quantity <= cfg_wdata[QTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(win_len) > MAX_WINDOW) begin
      clamp_w = AW'(MAX_WINDOW);
    end else begin
      clamp_w = AW'(win_len);
    end
    first   = (cells_seen == '0);
    eff_w   = first ? clamp_w : act_window;
    eff_q   = first ? quantity : act_quantity;
    eff_h   = eff_w >> 1;
    eff_2h  = eff_w & ~AW'(1);
    c_ge_h  = cells_seen >= CNT_W'(eff_h);
    c_ge_2h = cells_seen >= CNT_W'(eff_2h);
    h_cur   = act_window >> 1;
    two_h   = act_window & ~AW'(1);
    raw_back = main_pend ? h_cur : fl_cnt - AW'(1);
    wr_addr = wr_pos + AW'(1);
    rd_addr = cmd.rd_sort ? (wr_pos - two_h + k) : (wr_pos - raw_back);
    wr_data = {in_data.velocity, in_data.power, in_data.spectral_width};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_window   <= AW'(3);
      act_quantity <= QTY_VELOCITY;
      cells_seen   <= '0;
      wr_pos       <= '1;
      main_pend    <= 1'b0;
      main_filt    <= 1'b0;
      main_last    <= 1'b0;
      fl_cnt       <= '0;
    end else if (cmd.accept) begin
      act_window   <= eff_w;
      act_quantity <= eff_q;
      wr_pos       <= wr_addr;
      main_pend    <= c_ge_h;
      main_filt    <= c_ge_2h && (eff_w != '0) && (eff_q != QTY_NONE);
      main_last    <= in_data.last && (eff_h == '0);
      if (in_data.last) begin
        fl_cnt     <= c_ge_h ? eff_h : AW'(cells_seen) + AW'(1);
        cells_seen <= '0;
      end else begin
        fl_cnt     <= '0;
        cells_seen <= (cells_seen != '1) ? cells_seen + CNT_W'(1) : cells_seen;
      end
    end else if (cmd.emit) begin
      if (main_pend) begin
        main_pend <= 1'b0;
      end else begin
        fl_cnt <= fl_cnt - AW'(1);
      end
    end
  end

  swmf_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_vld  <= 1'b0;
      sort_vld <= 1'b0;
      k        <= '0;
    end else begin
      raw_vld  <= cmd.rd_raw;
      sort_vld <= cmd.rd_sort;
      if (cmd.rd_raw) begin
        k <= '0;
      end else if (cmd.rd_sort) begin
        k <= k + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (raw_vld) begin
      held_cell <= rd_data;
    end
  end

  always_comb begin
    case (swmf_qty_t'(act_quantity))
      QTY_VELOCITY: sort_val = rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      QTY_POWER:    sort_val = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
      default:      sort_val = rd_data[SAMPLE_BITS-1:0];
    endcase
  end

  swmf_sort #(
    .LANES (DEPTH)
  ) u_sort (
    .clk    (clk),
    .rst    (rst),
    .clear  (cmd.rd_raw),
    .insert (sort_vld),
    .value  (sort_val),
    .sel    (h_cur),
    .median (median)
  );

  always_comb begin
    cur_filt = main_pend && main_filt;
    cur_last = main_pend ? main_last : (fl_cnt == AW'(1));
    vel = held_cell[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    pwr = held_cell[2*SAMPLE_BITS-1:SAMPLE_BITS];
    wid = held_cell[SAMPLE_BITS-1:0];
    if (cur_filt) begin
      case (swmf_qty_t'(act_quantity))
        QTY_VELOCITY: vel = median;
        QTY_POWER:    pwr = median;
        QTY_WIDTH:    wid = median;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= '{out_velocity: vel, out_power: pwr, out_width: wid,
                    out_last: cur_last};
    end
  end

  always_comb begin
    sts.pending   = main_pend || (fl_cnt != '0);
    sts.filt      = cur_filt;
    sts.sort_done = (k == act_window - AW'(1));
    sts.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_median_filter.sv =====
// Top level: running median filter over a stream of grid cells.
//
//  channel | signals                          | direction | transaction
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_data      | input     | one cell
//  out     | out_valid, out_ready, out_data   | output    | one cell, filtered or raw
//  cfg     | cfg_we, cfg_addr, cfg_wdata      | input     | one register write
//
// One cell is taken at a time. After accept and planning each result is sent raw or
// filtered; for a filtered result the W samples of the window (W = window size)
// are read one per cycle from the single read port of the cell ring and inserted
// into the sorter. A held output register lets the next cell in while the last
// result waits. Reset is synchronous; the ring needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_median_filter
  import swmf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire swmf_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output swmf_out_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  swmf_cmd_t cmd;
  swmf_sts_t sts;

  swmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmf_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule
`default_nettype wire
